// ----- hdl/seinal_pkg.sv -----
`timescale 1ns / 1ps

package seinal_pkg;

    // Field widths of the item and result channels.
    localparam int TYPE_W   = 10;
    localparam int SIZE_W   = 12;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 13;
    localparam int UUID_W   = 64;
    localparam int CFG_IDX_W = 1;

    // Item function codes.
    localparam logic FUNC_BEGIN = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_UUID_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UUID_LOW  = 1'b1;

    // Byte values of the NAL unit.
    localparam logic [BYTE_W-1:0] START_ZERO   = 8'h00;
    localparam logic [BYTE_W-1:0] START_ONE    = 8'h01;
    localparam logic [BYTE_W-1:0] NAL_HDR_SEI  = 8'h06;
    localparam logic [BYTE_W-1:0] EP_BYTE      = 8'h03;
    localparam logic [BYTE_W-1:0] FF_BYTE      = 8'hFF;
    localparam logic [BYTE_W-1:0] TRAIL_BYTE   = 8'h80;
    localparam logic [BYTE_W-1:0] EP_LIMIT     = 8'h03;

    // Coding step of type and size, and the UUID length added to the size.
    localparam logic [LEN_W-1:0] CODE_STEP  = 13'd255;
    localparam logic [LEN_W-1:0] UUID_BYTES = 13'd16;

    // Command queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic              is_data;
        logic              last;
        logic [TYPE_W-1:0] ptype;
        logic [SIZE_W-1:0] size;
        logic [BYTE_W-1:0] dbyte;
    } cmd_t;

endpackage

// ----- hdl/seinal_item_if.sv -----
`timescale 1ns / 1ps

interface seinal_item_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [seinal_pkg::TYPE_W-1:0]       payload_type;
    logic [seinal_pkg::SIZE_W-1:0]       payload_len;
    logic [seinal_pkg::BYTE_W-1:0]       data_byte;

    modport source (output valid, func, payload_type, payload_len, data_byte, input ready);
    modport sink   (input valid, func, payload_type, payload_len, data_byte, output ready);
endinterface

// ----- hdl/seinal_byte_if.sv -----
`timescale 1ns / 1ps

interface seinal_byte_if;
    logic                                valid;
    logic                                ready;
    logic [seinal_pkg::BYTE_W-1:0]       out_byte;
    logic                                last_byte;
    logic [seinal_pkg::LEN_W-1:0]        total_length;

    modport source (output valid, out_byte, last_byte, total_length, input ready);
    modport sink   (input valid, out_byte, last_byte, total_length, output ready);
endinterface

// ----- hdl/h264_sei_user_data_nal_writer.sv -----
`timescale 1ns / 1ps

// Builds H.264 SEI NAL units as a byte stream, one result item per byte.
// A begin item (func 0) produces the start code, the SEI header byte, the
// coded payload type and size (size plus 16), the 16 UUID bytes from the
// two configuration registers and, for a zero size, the trailing 0x80 byte.
// Each data item (func 1) produces its payload byte, and the trailing byte
// follows the last one; the trailing byte carries last_byte and the total
// unit length. Data items arriving outside a message are dropped. Every byte
// after the start code passes through emulation prevention, so an inserted
// 0x03 goes out ahead of the byte that caused it. The output sequencer sends
// one byte per cycle while the output is not stalled; a begin item first
// takes a setup step in which no byte goes out. A four-entry command queue
// sits between the item front end and the byte sequencer, so items keep
// being accepted while header bytes go out until the queue is full, and
// the output register takes a new byte as the previous one is taken.
// Configuration must only be written while idle.
module h264_sei_user_data_nal_writer #(
    parameter int MAX_PAYLOAD_BYTES = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    seinal_item_if.sink                      items,
    seinal_byte_if.source                    stream,
    input  logic                             cfg_we,
    input  logic [seinal_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [seinal_pkg::UUID_W-1:0]    cfg_data
);
    import seinal_pkg::*;

    // UUID registers, read by the sequencer as the UUID bytes go out.
    logic [UUID_W-1:0] uuid_high_reg, uuid_high_next;
    logic [UUID_W-1:0] uuid_low_reg, uuid_low_next;

    logic push_valid;
    cmd_t push_cmd;
    logic push_ready;
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    always_comb
    begin
        uuid_high_next = uuid_high_reg;
        uuid_low_next  = uuid_low_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_UUID_HIGH: uuid_high_next = cfg_data;
                REG_UUID_LOW:  uuid_low_next  = cfg_data;
                default:       uuid_high_next = uuid_high_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uuid_high_reg <= '0;
            uuid_low_reg  <= '0;
        end
        else
        begin
            uuid_high_reg <= uuid_high_next;
            uuid_low_reg  <= uuid_low_next;
        end
    end

    // The front end tracks the open message and turns items into commands.
    seinal_front #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    seinal_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    // The back end sequences the bytes and applies emulation prevention.
    seinal_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .uuid_high  (uuid_high_reg),
        .uuid_low   (uuid_low_reg),
        .stream     (stream)
    );

endmodule

// ----- hdl/seinal_front.sv -----
`timescale 1ns / 1ps

module seinal_front #(
    parameter int MAX_PAYLOAD_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    seinal_item_if.sink        items,
    output logic               push_valid,
    output seinal_pkg::cmd_t   push_cmd,
    input  logic               push_ready
);
    import seinal_pkg::*;

    localparam logic [16:0] MaxBytes = 17'(MAX_PAYLOAD_BYTES);

    logic              open_reg, open_next;
    logic [SIZE_W-1:0] remain_reg, remain_next;
    logic              accept;
    logic              is_data;
    logic [SIZE_W-1:0] size_eff;

    assign items.ready = push_ready;
    assign accept      = items.valid && push_ready;
    assign is_data     = (items.func == FUNC_DATA);
    assign size_eff    = ({5'd0, items.payload_len} > MaxBytes) ? MaxBytes[SIZE_W-1:0]
                                                                : items.payload_len;

    // Data outside an open message is dropped here and never reaches the queue.
    assign push_valid       = accept && (!is_data || open_reg);
    assign push_cmd.is_data = is_data;
    assign push_cmd.last    = (remain_reg == 12'd1);
    assign push_cmd.ptype   = items.payload_type;
    assign push_cmd.size    = size_eff;
    assign push_cmd.dbyte   = items.data_byte;

    always_comb
    begin
        open_next   = open_reg;
        remain_next = remain_reg;
        if (accept && !is_data)
        begin
            open_next   = (size_eff != 12'd0);
            remain_next = size_eff;
        end
        else if (accept && open_reg)
        begin
            remain_next = remain_reg - 12'd1;
            if (remain_reg == 12'd1)
            begin
                open_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            open_reg   <= open_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// ----- hdl/seinal_fifo.sv -----
`timescale 1ns / 1ps

module seinal_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  seinal_pkg::cmd_t  push_cmd,
    output logic              push_ready,
    output logic              head_valid,
    output seinal_pkg::cmd_t  head_cmd,
    input  logic              pop
);
    import seinal_pkg::*;

    cmd_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (do_push ? 2'd1 : 2'd0);
        rd_ptr_next = rd_ptr_reg + (do_pop ? 2'd1 : 2'd0);
        count_next  = count_reg + (do_push ? 3'd1 : 3'd0) - (do_pop ? 3'd1 : 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/seinal_back.sv -----
`timescale 1ns / 1ps

module seinal_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  seinal_pkg::cmd_t              head_cmd,
    output logic                          pop,
    input  logic [seinal_pkg::UUID_W-1:0] uuid_high,
    input  logic [seinal_pkg::UUID_W-1:0] uuid_low,
    seinal_byte_if.source                 stream
);
    import seinal_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_HDR   = 3'd2;
    localparam logic [2:0] ST_CODE  = 3'd3;
    localparam logic [2:0] ST_UUID  = 3'd4;
    localparam logic [2:0] ST_TRAIL = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [LEN_W-1:0]  v_reg, v_next;
    logic              sel_size_reg, sel_size_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [1:0]        zrun_reg, zrun_next;
    logic [LEN_W-1:0]  bw_reg, bw_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;

    logic              adv;
    logic              cand_valid;
    logic [BYTE_W-1:0] cand_byte;
    logic              cand_ep;
    logic              cand_last;
    logic              ins;
    logic              emit;
    logic              step;
    logic              load_begin;
    logic [LEN_W-1:0]  bw_inc;
    logic [127:0]      uuid_cat;
    logic [6:0]        ubit;
    logic              v_big;

    assign adv      = !out_valid_reg || stream.ready;
    assign uuid_cat = {uuid_high, uuid_low};
    assign ubit     = {~cnt_reg, 3'b111};
    assign v_big    = (v_reg >= CODE_STEP);
    assign bw_inc   = bw_reg + 13'd1;

    // Next byte the sequencer wants to send, before emulation prevention.
    always_comb
    begin
        cand_valid = 1'b1;
        cand_byte  = START_ZERO;
        cand_ep    = 1'b1;
        cand_last  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cand_valid = head_valid && head_cmd.is_data;
                cand_byte  = head_cmd.dbyte;
            end
            ST_START:
            begin
                cand_byte = (cnt_reg == 4'd3) ? START_ONE : START_ZERO;
                cand_ep   = 1'b0;
            end
            ST_HDR:
            begin
                cand_byte = NAL_HDR_SEI;
            end
            ST_CODE:
            begin
                cand_byte = v_big ? FF_BYTE : v_reg[BYTE_W-1:0];
            end
            ST_UUID:
            begin
                cand_byte = uuid_cat[ubit -: 8];
            end
            ST_TRAIL:
            begin
                cand_byte = TRAIL_BYTE;
                cand_last = 1'b1;
            end
            default:
            begin
                cand_valid = 1'b0;
            end
        endcase
    end

    assign ins        = cand_ep && (zrun_reg == 2'd2) && (cand_byte <= EP_LIMIT);
    assign emit       = adv && cand_valid;
    assign step       = emit && !ins;
    assign load_begin = (state_reg == ST_IDLE) && head_valid && !head_cmd.is_data;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        v_next        = v_reg;
        sel_size_next = sel_size_reg;
        size_next     = size_reg;
        pop           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (load_begin)
                begin
                    pop           = 1'b1;
                    v_next        = {3'd0, head_cmd.ptype};
                    size_next     = head_cmd.size;
                    sel_size_next = 1'b0;
                    cnt_next      = '0;
                    state_next    = ST_START;
                end
                else if (step)
                begin
                    pop = 1'b1;
                    if (head_cmd.last)
                    begin
                        state_next = ST_TRAIL;
                    end
                end
            end
            ST_START:
            begin
                if (step)
                begin
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd3)
                    begin
                        state_next = ST_HDR;
                    end
                end
            end
            ST_HDR:
            begin
                if (step)
                begin
                    state_next = ST_CODE;
                end
            end
            ST_CODE:
            begin
                if (step)
                begin
                    if (v_big)
                    begin
                        v_next = v_reg - CODE_STEP;
                    end
                    else if (!sel_size_reg)
                    begin
                        v_next        = {1'b0, size_reg} + UUID_BYTES;
                        sel_size_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = ST_UUID;
                    end
                end
            end
            ST_UUID:
            begin
                if (step)
                begin
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        state_next = (size_reg == 12'd0) ? ST_TRAIL : ST_IDLE;
                    end
                end
            end
            ST_TRAIL:
            begin
                if (step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        zrun_next      = zrun_reg;
        bw_next        = bw_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_len_next   = out_len_reg;
        if (load_begin)
        begin
            zrun_next = '0;
            bw_next   = '0;
        end
        else if (emit)
        begin
            bw_next = bw_inc;
            if (ins)
            begin
                zrun_next = '0;
            end
            else if (cand_ep)
            begin
                if (cand_byte != 8'd0)
                begin
                    zrun_next = '0;
                end
                else if (zrun_reg != 2'd2)
                begin
                    zrun_next = zrun_reg + 2'd1;
                end
            end
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = ins ? EP_BYTE : cand_byte;
            out_last_next  = !ins && cand_last;
            out_len_next   = (!ins && cand_last) ? bw_inc : '0;
        end
        else if (stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sel_size_reg  <= 1'b0;
            zrun_reg      <= '0;
            bw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sel_size_reg  <= sel_size_next;
            zrun_reg      <= zrun_next;
            bw_reg        <= bw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        size_reg     <= size_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_len_reg  <= out_len_next;
    end

    assign stream.valid        = out_valid_reg;
    assign stream.out_byte     = out_byte_reg;
    assign stream.last_byte    = out_last_reg;
    assign stream.total_length = out_len_reg;

endmodule
